@@ design/btffa_pkg.sv @@
// Shared types for the boundary-tag first-fit allocator.
// Holds operation and status codes, the controller states and the
// command and status structs between the controller and the datapath.
package btffa_pkg;

  localparam int BTFFA_ARENA_WORDS = 4096;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_EXTEND = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADADDR = 2'd2,
    ST_BADEXT  = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    DC_IDLE,
    DC_LOAD,
    DC_INIT_HEAD,
    DC_INIT_TAIL,
    DC_RD_H,
    DC_RD_PREV,
    DC_RD_NEXT,
    DC_RD_LAST,
    DC_ADV,
    DC_TAKE,
    DC_MRG_PREV,
    DC_MRG_NEXT,
    DC_X_USED,
    DC_X_FREE,
    DC_SPLIT,
    DC_WR_UHEAD,
    DC_WR_UTAIL,
    DC_WR_NHEAD,
    DC_WR_NTAIL,
    DC_WR_FHEAD,
    DC_WR_FTAIL,
    DC_FIN
  } dp_cmd_t;

  typedef enum logic [4:0] {
    S_INIT_H,
    S_INIT_T,
    S_IDLE,
    S_DEC,
    S_A_RD,
    S_A_CHK,
    S_A_SEL,
    S_WU_H,
    S_WU_T,
    S_WN_H,
    S_WN_T,
    S_SPLIT,
    S_F_RD,
    S_F_CHK,
    S_F_PRV,
    S_F_PCHK,
    S_F_NXT,
    S_F_NCHK,
    S_X_RD,
    S_X_CHK,
    S_WF_H,
    S_WF_T,
    S_FIN
  } state_t;

  typedef struct packed {
    dp_cmd_t cmd;
    status_t code;
  } dp_ctl_t;

  typedef struct packed {
    op_t  op;
    logic n_zero;
    logic n_lt2;
    logic ext_bad;
    logic addr_bad;
    logic rused;
    logic fit;
    logic walk_end;
    logic next_out;
    logic full_take;
    logic hit;
    logic miss;
    logic h_zero;
    logic t_last;
  } dp_stat_t;

endpackage

@@ design/btffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btffa_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/btffa_ctrl.sv @@
// Controller state machine of the allocator.
// Depends on btffa_pkg; drives datapath commands and the handshakes.
module btffa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  btffa_pkg::dp_stat_t stat,
  output btffa_pkg::dp_ctl_t  ctl
);
  import btffa_pkg::*;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    out_busy;
  logic    accept;

  assign out_busy  = out_valid_r && out_stall;
  assign in_stall  = (state_r != S_IDLE) || cfg_wr_en;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    unique case (state_r)
      S_INIT_H: state_nxt = S_INIT_T;
      S_INIT_T: state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_wr_en) begin
          state_nxt = S_INIT_H;
        end else if (accept) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        code_nxt = ST_OK;
        unique case (stat.op)
          OP_ALLOC: begin
            if (stat.n_zero) begin
              code_nxt  = ST_NOFIT;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_A_RD;
            end
          end
          OP_FREE: begin
            if (stat.addr_bad) begin
              code_nxt  = ST_BADADDR;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_F_RD;
            end
          end
          OP_EXTEND: begin
            if (stat.n_zero || stat.ext_bad) begin
              code_nxt  = ST_BADEXT;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_X_RD;
            end
          end
          default: begin
            code_nxt  = ST_BADEXT;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (stat.fit) begin
          state_nxt = S_A_SEL;
        end else if (stat.walk_end || stat.next_out) begin
          code_nxt  = ST_NOFIT;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_SEL: state_nxt = stat.full_take ? S_WU_H : S_WN_H;
      S_WU_H:  state_nxt = S_WU_T;
      S_WU_T:  state_nxt = S_FIN;
      S_WN_H:  state_nxt = S_WN_T;
      S_WN_T:  state_nxt = S_SPLIT;
      S_SPLIT: state_nxt = S_WF_H;
      S_F_RD:  state_nxt = S_F_CHK;
      S_F_CHK: begin
        if (stat.hit) begin
          if (!stat.rused) begin
            code_nxt  = ST_BADADDR;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_F_PRV;
          end
        end else if (stat.miss || stat.walk_end || stat.next_out) begin
          code_nxt  = ST_BADADDR;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_F_PRV:  state_nxt = stat.h_zero ? S_F_NXT : S_F_PCHK;
      S_F_PCHK: state_nxt = S_F_NXT;
      S_F_NXT:  state_nxt = stat.t_last ? S_WF_H : S_F_NCHK;
      S_F_NCHK: state_nxt = S_WF_H;
      S_X_RD:   state_nxt = S_X_CHK;
      S_X_CHK: begin
        if (stat.rused && stat.n_lt2) begin
          code_nxt  = ST_BADEXT;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_WF_H;
        end
      end
      S_WF_H: state_nxt = S_WF_T;
      S_WF_T: state_nxt = S_FIN;
      S_FIN: begin
        if (!out_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    ctl.cmd  = DC_IDLE;
    ctl.code = code_r;
    unique case (state_r)
      S_INIT_H: ctl.cmd = DC_INIT_HEAD;
      S_INIT_T: ctl.cmd = DC_INIT_TAIL;
      S_IDLE:   ctl.cmd = accept ? DC_LOAD : DC_IDLE;
      S_A_RD:   ctl.cmd = DC_RD_H;
      S_A_CHK: begin
        if (stat.fit) begin
          ctl.cmd = DC_TAKE;
        end else if (!(stat.walk_end || stat.next_out)) begin
          ctl.cmd = DC_ADV;
        end
      end
      S_WU_H:  ctl.cmd = DC_WR_UHEAD;
      S_WU_T:  ctl.cmd = DC_WR_UTAIL;
      S_WN_H:  ctl.cmd = DC_WR_NHEAD;
      S_WN_T:  ctl.cmd = DC_WR_NTAIL;
      S_SPLIT: ctl.cmd = DC_SPLIT;
      S_F_RD:  ctl.cmd = DC_RD_H;
      S_F_CHK: begin
        if (stat.hit) begin
          ctl.cmd = stat.rused ? DC_TAKE : DC_IDLE;
        end else if (!(stat.miss || stat.walk_end || stat.next_out)) begin
          ctl.cmd = DC_ADV;
        end
      end
      S_F_PRV:  ctl.cmd = stat.h_zero ? DC_IDLE : DC_RD_PREV;
      S_F_PCHK: ctl.cmd = stat.rused ? DC_IDLE : DC_MRG_PREV;
      S_F_NXT:  ctl.cmd = stat.t_last ? DC_IDLE : DC_RD_NEXT;
      S_F_NCHK: ctl.cmd = stat.rused ? DC_IDLE : DC_MRG_NEXT;
      S_X_RD:   ctl.cmd = DC_RD_LAST;
      S_X_CHK: begin
        if (!stat.rused) begin
          ctl.cmd = DC_X_FREE;
        end else if (!stat.n_lt2) begin
          ctl.cmd = DC_X_USED;
        end
      end
      S_WF_H: ctl.cmd = DC_WR_FHEAD;
      S_WF_T: ctl.cmd = DC_WR_FTAIL;
      S_FIN:  ctl.cmd = out_busy ? DC_IDLE : DC_FIN;
      default: ctl.cmd = DC_IDLE;
    endcase
  end

  // hold the result valid until taken
  always_comb begin
    out_valid_nxt = out_busy;
    if (state_r == S_FIN && !out_busy) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT_H;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted request is decoded next
  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DEC) else $error("request not decoded");

  // a finished request waits while the output is occupied
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> state_r == S_FIN)
    else $error("result overwritten");

  // a new result appears only out of the finish state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r) == S_FIN)
    else $error("result without finish");

  // tag initialization writes head then tail
  a_init_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT_H |=> state_r == S_INIT_T)
    else $error("init sequence broken");

endmodule

@@ design/btffa_dp.sv @@
// Datapath of the allocator: tag RAM, walk pointers, partition end,
// partition size register and result registers. Depends on btffa_pkg, btffa_ram.
module btffa_dp #(
  parameter int ARENA_WORDS = btffa_pkg::BTFFA_ARENA_WORDS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [12:0]         cfg_wr_data,
  input  logic [1:0]          in_operation,
  input  logic [12:0]         in_amount_words,
  input  logic [11:0]         in_payload_addr,
  input  btffa_pkg::dp_ctl_t  ctl,
  output btffa_pkg::dp_stat_t stat,
  output logic [1:0]          out_status,
  output logic [11:0]         out_result_addr,
  output logic [11:0]         out_partition_end
);
  import btffa_pkg::*;

  localparam int AW = $clog2(ARENA_WORDS);
  localparam int WW = ((AW > 13) ? AW : 13) + 2;
  localparam logic [12:0] INIT_RST = (ARENA_WORDS < 4096) ? 13'(ARENA_WORDS) : 13'd4096;

  op_t         op_r;
  logic [12:0] amt_r;
  logic [11:0] paddr_r;
  logic [AW-1:0] h_r, sz_r, t_r, last_r;
  logic [AW-1:0] grant_r;
  logic [12:0] init_r;
  logic [12:0] cfg_sat;

  logic [AW:0]   rdata;
  logic          rused;
  logic [WW-1:0] hw, szw, tw, lastw, nw, aw, rszw, initw;
  logic [WW-1:0] wa;
  logic          wused;
  logic [AW-1:0] wsize;
  logic          wcmd;
  logic [AW-1:0] raddr;

  assign rused = rdata[AW];
  assign hw    = WW'(h_r);
  assign szw   = WW'(sz_r);
  assign tw    = WW'(t_r);
  assign lastw = WW'(last_r);
  assign nw    = WW'(amt_r);
  assign aw    = WW'(paddr_r);
  assign rszw  = WW'(rdata[AW-1:0]);
  assign initw = WW'(init_r);

  // status flags for the controller
  always_comb begin
    stat.op        = op_r;
    stat.n_zero    = (amt_r == 13'd0);
    stat.n_lt2     = (amt_r < 13'd2);
    stat.ext_bad   = (lastw + nw) > WW'(ARENA_WORDS - 1);
    stat.addr_bad  = (aw < WW'(1)) || (aw >= lastw);
    stat.rused     = rused;
    stat.fit       = !rused && (nw <= rszw);
    stat.walk_end  = (hw + rszw + WW'(1)) >= lastw;
    stat.next_out  = (hw + rszw + WW'(2)) >= WW'(ARENA_WORDS);
    stat.full_take = (nw + WW'(2)) >= szw;
    stat.hit       = (hw + WW'(1)) == aw;
    stat.miss      = (hw + WW'(1)) > aw;
    stat.h_zero    = (h_r == '0);
    stat.t_last    = (t_r == last_r);
  end

  // tag write select
  always_comb begin
    wcmd  = 1'b1;
    wa    = hw;
    wused = 1'b0;
    wsize = sz_r;
    unique case (ctl.cmd)
      DC_INIT_HEAD: begin
        wa    = '0;
        wsize = AW'(initw - WW'(2));
      end
      DC_INIT_TAIL: begin
        wa    = initw - WW'(1);
        wsize = AW'(initw - WW'(2));
      end
      DC_WR_UHEAD: wused = 1'b1;
      DC_WR_UTAIL: begin
        wa    = hw + szw + WW'(1);
        wused = 1'b1;
      end
      DC_WR_NHEAD: begin
        wused = 1'b1;
        wsize = AW'(nw);
      end
      DC_WR_NTAIL: begin
        wa    = hw + nw + WW'(1);
        wused = 1'b1;
        wsize = AW'(nw);
      end
      DC_WR_FHEAD: ;
      DC_WR_FTAIL: wa = hw + szw + WW'(1);
      default: wcmd = 1'b0;
    endcase
  end

  // tag read address
  always_comb begin
    unique case (ctl.cmd)
      DC_RD_PREV: raddr = AW'(hw - WW'(1));
      DC_RD_NEXT: raddr = AW'(tw + WW'(1));
      DC_RD_LAST: raddr = last_r;
      default:    raddr = h_r;
    endcase
  end

  btffa_ram #(
    .W (AW + 1),
    .D (ARENA_WORDS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (wcmd && (wa < WW'(ARENA_WORDS))),
    .waddr (wa[AW-1:0]),
    .wdata ({wused, wsize}),
    .raddr (raddr),
    .rdata (rdata)
  );

  // clamp the partition size to at least 2 and at most the arena
  always_comb begin
    cfg_sat = cfg_wr_data;
    if (cfg_wr_data < 13'd2) begin
      cfg_sat = 13'd2;
    end else if (WW'(cfg_wr_data) > WW'(ARENA_WORDS)) begin
      cfg_sat = 13'(ARENA_WORDS);
    end
  end

  // partition size and partition end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= INIT_RST;
      last_r <= AW'(WW'(INIT_RST) - WW'(1));
    end else begin
      if (cfg_wr_en) begin
        init_r <= cfg_sat;
      end
      unique case (ctl.cmd)
        DC_INIT_HEAD:         last_r <= AW'(initw - WW'(1));
        DC_X_USED, DC_X_FREE: last_r <= AW'(lastw + nw);
        default: ;
      endcase
    end
  end

  // walk pointers, request fields and result
  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      DC_LOAD: begin
        op_r    <= op_t'(in_operation);
        amt_r   <= in_amount_words;
        paddr_r <= in_payload_addr;
        h_r     <= '0;
      end
      DC_ADV: h_r <= AW'(hw + rszw + WW'(2));
      DC_TAKE: begin
        sz_r    <= rdata[AW-1:0];
        t_r     <= AW'(hw + rszw + WW'(1));
        // keep the granted payload address before a split moves the pointer
        grant_r <= AW'(hw + WW'(1));
      end
      DC_MRG_PREV: begin
        sz_r <= AW'(szw + rszw + WW'(2));
        h_r  <= AW'(hw - rszw - WW'(2));
      end
      DC_MRG_NEXT: sz_r <= AW'(szw + rszw + WW'(2));
      DC_X_USED: begin
        h_r  <= AW'(lastw + WW'(1));
        sz_r <= AW'(nw - WW'(2));
      end
      DC_X_FREE: begin
        h_r  <= AW'(lastw - rszw - WW'(1));
        sz_r <= AW'(rszw + nw);
      end
      DC_SPLIT: begin
        h_r  <= AW'(hw + nw + WW'(2));
        sz_r <= AW'(szw - nw - WW'(2));
      end
      DC_FIN: begin
        out_status        <= ctl.code;
        out_result_addr   <= (ctl.code == ST_OK && op_r == OP_ALLOC) ?
                             12'(grant_r) : 12'd0;
        out_partition_end <= 12'(lastw);
      end
      default: ;
    endcase
  end

endmodule

@@ design/boundary_tag_first_fit_allocator.sv @@
// Boundary-tag first-fit allocator. One request (allocate, free, extend)
// is worked at a time; each result appears on the out_ channel and may wait
// there while the next request is taken. All tag reads and writes go through
// the tag RAM. Allocate walks the blocks from the first until one fits, then
// writes the used head and tail tags and, when the block is split, the free
// tags of the rest; free walks to the block, merges it with a free block
// below and one above and writes its free tags; extend reads the last tag
// and grows the last block or adds a free one; a request rejected at decode
// goes straight to the result. The next request can be taken in the cycle
// after the result is formed. After reset or a cfg write the partition is
// re-formed, head tag then tail tag, during which requests are stalled.
module boundary_tag_first_fit_allocator #(
  parameter int ARENA_WORDS = btffa_pkg::BTFFA_ARENA_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [12:0] in_amount_words,
  input  logic [11:0] in_payload_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [11:0] out_result_addr,
  output logic [11:0] out_partition_end
);
  import btffa_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  // sequence requests
  btffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  // hold tags and pointers
  btffa_dp #(
    .ARENA_WORDS (ARENA_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_operation      (in_operation),
    .in_amount_words   (in_amount_words),
    .in_payload_addr   (in_payload_addr),
    .ctl               (ctl),
    .stat              (stat),
    .out_status        (out_status),
    .out_result_addr   (out_result_addr),
    .out_partition_end (out_partition_end)
  );

endmodule

@@ tb/tb.sv @@
// Testbench for the boundary-tag first-fit allocator: directed table then random traffic,
// every result checked against the table's expected values or an in-bench tag-store predictor.
// Depends on btffa_pkg and boundary_tag_first_fit_allocator.
module tb;
  import btffa_pkg::*;

  typedef struct {
    status_t     st;
    logic [11:0] addr;
    logic [11:0] pend;
  } alloc_result_t;

  typedef struct {
    bit          has_exp;
    alloc_result_t res;
  } typed_exp_t;

  typedef struct {
    bit          is_cfg;
    logic [12:0] cfg_val;
    op_t         op;
    logic [12:0] amt;
    logic [11:0] pa;
    bit          has_exp;
    alloc_result_t res;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [12:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_operation;
  logic [12:0] in_amount_words;
  logic [11:0] in_payload_addr;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [11:0] out_result_addr;
  logic [11:0] out_partition_end;

  boundary_tag_first_fit_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_amount_words(in_amount_words),
    .in_payload_addr(in_payload_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_addr(out_result_addr),
    .out_partition_end(out_partition_end)
  );

  // Predicted tag store and partition state
  logic [12:0] tag_sz [BTFFA_ARENA_WORDS];
  bit          tag_used [BTFFA_ARENA_WORDS];
  int unsigned last_tail;
  int unsigned part_words;
  int unsigned live_addrs[$];

  alloc_result_t result_q[$];
  typed_exp_t    typed_q[$];
  dir_row_t      dir_rows[$];
  int            n_issued = 0;
  int            n_checked = 0;
  int            fails = 0;
  bit            no_idle = 0;
  logic          hold_off = 1'b0;
  int            stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void put_tag(int unsigned a, bit u, int unsigned s);
    if (a < BTFFA_ARENA_WORDS) begin
      tag_used[a] = u;
      tag_sz[a] = s[12:0];
    end
  endfunction

  function automatic void put_block(int unsigned h, bit u, int unsigned s);
    put_tag(h, u, s);
    put_tag(h + s + 1, u, s);
  endfunction

  function automatic void reform_partition(logic [12:0] v);
    int unsigned w;
    w = v;
    if (w < 2) w = 2;
    if (w > BTFFA_ARENA_WORDS) w = BTFFA_ARENA_WORDS;
    part_words = w;
    for (int i = 0; i < BTFFA_ARENA_WORDS; i++) begin
      tag_sz[i] = '0;
      tag_used[i] = 1'b0;
    end
    put_block(0, 1'b0, w - 2);
    last_tail = w - 1;
    live_addrs.delete();
  endfunction

  // Work out one request against the predicted store and update it
  function automatic alloc_result_t predict_request(logic [1:0] op_bits, int unsigned n,
                                                    int unsigned pa);
    alloc_result_t r;
    int unsigned h, s, t, ps;
    bit found, done;
    r.st = ST_OK;
    r.addr = '0;
    h = 0;
    s = 0;
    found = 0;
    done = 0;
    case (op_t'(op_bits))
      OP_ALLOC: begin
        if (n == 0) begin
          r.st = ST_NOFIT;
        end else begin
          while (!done) begin
            if (h >= BTFFA_ARENA_WORDS) begin
              done = 1;
            end else begin
              s = tag_sz[h];
              if (!tag_used[h] && n <= s) begin
                found = 1;
                done = 1;
              end else if (h + s + 1 >= last_tail) begin
                done = 1;
              end else begin
                h = h + s + 2;
              end
            end
          end
          if (!found) begin
            r.st = ST_NOFIT;
          end else begin
            if (n + 2 >= s) begin
              put_block(h, 1'b1, s);
            end else begin
              put_block(h, 1'b1, n);
              put_block(h + n + 2, 1'b0, s - n - 2);
            end
            r.addr = h + 1;
            live_addrs.push_back(h + 1);
          end
        end
      end
      OP_FREE: begin
        if (pa < 1 || pa >= last_tail) begin
          r.st = ST_BADADDR;
        end else begin
          while (!done) begin
            if (h >= BTFFA_ARENA_WORDS) begin
              done = 1;
            end else begin
              s = tag_sz[h];
              if (h + 1 == pa) begin
                found = 1;
                done = 1;
              end else if (h + 1 > pa || h + s + 1 >= last_tail) begin
                done = 1;
              end else begin
                h = h + s + 2;
              end
            end
          end
          if (!found || !tag_used[h]) begin
            r.st = ST_BADADDR;
          end else begin
            t = h + s + 1;
            // merge with a free block below, then one above
            if (h != 0 && !tag_used[h - 1]) begin
              ps = tag_sz[h - 1];
              s = s + ps + 2;
              h = h - ps - 2;
            end
            if (t != last_tail && !tag_used[t + 1]) s = s + tag_sz[t + 1] + 2;
            put_block(h, 1'b0, s);
            foreach (live_addrs[i]) begin
              if (live_addrs[i] == pa) begin
                live_addrs.delete(i);
                break;
              end
            end
          end
        end
      end
      OP_EXTEND: begin
        if (n == 0 || last_tail + n > BTFFA_ARENA_WORDS - 1) begin
          r.st = ST_BADEXT;
        end else if (tag_used[last_tail]) begin
          if (n < 2) begin
            r.st = ST_BADEXT;
          end else begin
            put_block(last_tail + 1, 1'b0, n - 2);
            last_tail = last_tail + n;
          end
        end else begin
          s = tag_sz[last_tail];
          put_block(last_tail - s - 1, 1'b0, s + n);
          last_tail = last_tail + n;
        end
      end
      default: r.st = ST_BADEXT;
    endcase
    r.pend = last_tail[11:0];
    return r;
  endfunction

  // Predict each accepted request
  always @(posedge clk) begin
    alloc_result_t r;
    typed_exp_t te;
    if (rst_n && in_valid && !in_stall) begin
      r = predict_request(in_operation, in_amount_words, in_payload_addr);
      te = typed_q.pop_front();
      result_q.push_back(te.has_exp ? te.res : r);
    end
  end

  // Accept and check results; stall at random or during the long hold-off
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (result_q.size() == 0) begin
          $error("result with no request outstanding");
          fails++;
        end else begin
          e = result_q.pop_front();
          if (out_status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, out_status);
            fails++;
          end
          if (out_result_addr !== e.addr) begin
            $error("result_addr expected %0d actual %0d", e.addr, out_result_addr);
            fails++;
          end
          if (out_partition_end !== e.pend) begin
            $error("partition_end expected %0d actual %0d", e.pend, out_partition_end);
            fails++;
          end
        end
        stall_left = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) stall_left--;
      out_stall <= hold_off || (stall_left > 0);
    end
  end

  // Hold the receiver off long enough for the block to back up
  initial begin
    wait (n_issued >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_request(op_t op, logic [12:0] amt, logic [11:0] pa, bit has_exp,
                              alloc_result_t res);
    int gap;
    typed_exp_t te;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    te.has_exp = has_exp;
    te.res = res;
    typed_q.push_back(te);
    n_issued++;
    in_operation <= op;
    in_amount_words <= amt;
    in_payload_addr <= pa;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Drain, settle, then write the partition size
  task automatic write_partition(logic [12:0] v);
    in_valid <= 1'b0;
    wait (n_checked == n_issued);
    repeat (12) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    reform_partition(v);
  endtask

  function automatic void add_row(op_t op, logic [12:0] amt, logic [11:0] pa, bit has_exp,
                                  status_t st, logic [11:0] ra, logic [11:0] pe);
    dir_row_t d;
    d.is_cfg = 0;
    d.cfg_val = '0;
    d.op = op;
    d.amt = amt;
    d.pa = pa;
    d.has_exp = has_exp;
    d.res.st = st;
    d.res.addr = ra;
    d.res.pend = pe;
    dir_rows.push_back(d);
  endfunction

  function automatic void add_cfg(logic [12:0] v);
    dir_row_t d;
    d.is_cfg = 1;
    d.cfg_val = v;
    d.op = OP_ALLOC;
    d.amt = '0;
    d.pa = '0;
    d.has_exp = 0;
    d.res.st = ST_OK;
    d.res.addr = '0;
    d.res.pend = '0;
    dir_rows.push_back(d);
  endfunction

  initial begin
    alloc_result_t none;
    int unsigned amt, pa, cfg_v, pick;
    op_t op;
    none.st = ST_OK;
    none.addr = '0;
    none.pend = '0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_valid <= 1'b0;
    in_operation <= OP_ALLOC;
    in_amount_words <= '0;
    in_payload_addr <= '0;
    reform_partition(13'd4096);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, error codes, splits, merges, extends and partition writes
    add_row(OP_ALLOC, 13'd0, 12'd0, 1, ST_NOFIT, 12'd0, 12'd4095);
    add_row(OP_FREE, 13'd0, 12'd0, 1, ST_BADADDR, 12'd0, 12'd4095);
    add_row(OP_EXTEND, 13'd1, 12'd0, 1, ST_BADEXT, 12'd0, 12'd4095);
    add_row(OP_RSVD, 13'd8191, 12'd4095, 1, ST_BADEXT, 12'd0, 12'd4095);
    add_row(OP_ALLOC, 13'd4094, 12'd0, 1, ST_OK, 12'd1, 12'd4095);
    add_row(OP_ALLOC, 13'd1, 12'd0, 1, ST_NOFIT, 12'd0, 12'd4095);
    add_row(OP_FREE, 13'd0, 12'd1, 1, ST_OK, 12'd0, 12'd4095);
    add_row(OP_FREE, 13'd0, 12'd1, 1, ST_BADADDR, 12'd0, 12'd4095);
    add_row(OP_ALLOC, 13'd4096, 12'd0, 1, ST_NOFIT, 12'd0, 12'd4095);
    add_row(OP_ALLOC, 13'd8191, 12'd0, 1, ST_NOFIT, 12'd0, 12'd4095);
    add_row(OP_ALLOC, 13'd10, 12'd0, 0, ST_OK, 12'd0, 12'd0);
    add_row(OP_ALLOC, 13'd20, 12'd0, 0, ST_OK, 12'd0, 12'd0);
    add_row(OP_ALLOC, 13'd30, 12'd0, 0, ST_OK, 12'd0, 12'd0);
    add_row(OP_FREE, 13'd0, 12'd5, 1, ST_BADADDR, 12'd0, 12'd4095);
    add_row(OP_FREE, 13'd0, 12'd13, 0, ST_OK, 12'd0, 12'd0);
    add_row(OP_FREE, 13'd0, 12'd1, 0, ST_OK, 12'd0, 12'd0);
    add_row(OP_FREE, 13'd0, 12'd35, 0, ST_OK, 12'd0, 12'd0);
    add_row(OP_FREE, 13'd0, 12'd4095, 1, ST_BADADDR, 12'd0, 12'd4095);
    add_cfg(13'd8191);
    add_cfg(13'd0);
    add_row(OP_EXTEND, 13'd1, 12'd0, 1, ST_OK, 12'd0, 12'd2);
    add_row(OP_ALLOC, 13'd1, 12'd0, 1, ST_OK, 12'd1, 12'd2);
    add_row(OP_EXTEND, 13'd1, 12'd0, 1, ST_BADEXT, 12'd0, 12'd2);
    add_row(OP_EXTEND, 13'd2, 12'd0, 1, ST_OK, 12'd0, 12'd4);
    add_row(OP_EXTEND, 13'd4091, 12'd0, 1, ST_OK, 12'd0, 12'd4095);
    add_row(OP_EXTEND, 13'd1, 12'd0, 1, ST_BADEXT, 12'd0, 12'd4095);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_partition(dir_rows[i].cfg_val);
      end else begin
        send_request(dir_rows[i].op, dir_rows[i].amt, dir_rows[i].pa,
                     dir_rows[i].has_exp, dir_rows[i].res);
      end
    end

    // Random phases over several partition sizes
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: cfg_v = 4096;
        1: cfg_v = 2;
        2: cfg_v = 1;
        3: cfg_v = $urandom_range(0, 8191);
        default: cfg_v = $urandom_range(2, 600);
      endcase
      write_partition(cfg_v[12:0]);
      no_idle = (ph == 4 || ph == 7);
      for (int k = 0; k < 130; k++) begin
        pick = $urandom_range(0, 99);
        amt = 0;
        pa = 0;
        if (pick < 45) begin
          op = OP_ALLOC;
          amt = $urandom_range(1, (part_words / 8 > 1) ? part_words / 8 : 1);
          if (pick < 5) amt = $urandom_range(1, part_words);
        end else if (pick < 80) begin
          op = OP_FREE;
          if (live_addrs.size() > 0 && pick < 75)
            pa = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
          else
            pa = $urandom_range(0, 4095);
        end else if (pick < 92) begin
          op = OP_EXTEND;
          amt = $urandom_range(0, 40);
        end else begin
          // noise over every field bit
          op = op_t'($urandom_range(0, 3));
          amt = $urandom_range(0, 8191);
          pa = $urandom_range(0, 4095);
        end
        send_request(op, amt[12:0], pa[11:0], 0, none);
      end
    end

    in_valid <= 1'b0;
    wait (n_checked == n_issued);
    repeat (30) @(posedge clk);
    if (fails == 0 && result_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
